[rtl/core/rth_pkg.sv]
// Package for the RGB to HSI pixel converter.
// Holds the CORDIC angle table, the fixed hue widths and the sideband type.
// No dependencies.
`default_nettype none

package rth_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ZW = 27;
    localparam int QW = 8;
    localparam int SQRT3_Q15 = 56756;
    localparam logic signed [ZW-1:0] Z_90 = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] Z_180 = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] Z_360 = ZW'(360 * 65536);
    localparam logic [7:0] HUE_MAX = 8'd180;

    // atan(2^-i) in degrees times 2^16, rounded.
    localparam logic [21:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379, 22'd117304, 22'd58666, 22'd29335,
        22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115
    };

    typedef struct packed {
        logic gray;
        logic mirror;
    } t_hue_side;

endpackage

`default_nettype wire

[rtl/core/rgb_to_hsi_pixel.sv]
// Top level of the RGB to HSI pixel converter.
// Depends on rth_pkg, rth_cordic_cell and rth_div_cell.
//
// Usage: drive i_red, i_green and i_blue and raise start for one cycle per
// pixel. The request is taken at every rising edge where start is high and
// busy is low. busy is always low, so a new pixel may be issued in every
// cycle and the block sustains one pixel per clock.
//
// Each request produces exactly one result: o_hue (0..180, two degrees per
// unit), o_saturation and o_intensity (0..255). The result is driven with
// o_valid high once it has passed the input stage, the CORDIC row and the
// output stage. The receiver cannot stall the block; results must be
// taken when o_valid is high.
//
// Latency is set by the hue path: one input stage, a row of 16 CORDIC
// cells that each do one vectoring step, and one output stage for clamping,
// mirroring and rounding. Saturation goes through a row of eight restoring
// divider cells, one quotient bit per cell. Intensity divides by a constant,
// so it uses a reciprocal multiply in one stage. Both are then delayed to
// line up with the hue.
//
// Reset (i_rst_n low at a clock edge) clears all valid bits, so no result
// comes out until new requests arrive. Data registers are not reset.
`default_nettype none

module rgb_to_hsi_pixel #(
    parameter int COMPONENT_BITS = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [COMPONENT_BITS-1:0] i_red,
    input  wire logic [COMPONENT_BITS-1:0] i_green,
    input  wire logic [COMPONENT_BITS-1:0] i_blue,
    output logic                           o_valid,
    output logic [7:0]                     o_hue,
    output logic [7:0]                     o_saturation,
    output logic [7:0]                     o_intensity
);
    import rth_pkg::*;

    localparam int N = COMPONENT_BITS;
    localparam int SW = N + 2;          // sum of three components
    localparam int XW = N + 20;         // CORDIC vector width, with growth margin
    localparam int NW = N + 11;         // dividend and remainder width
    localparam int DW = N + 3;          // divisor width
    localparam int DIV_CELLS = QW;
    localparam int ALIGN = CORDIC_STEPS + 1 - DIV_CELLS;
    localparam logic [NW-1:0] M3 = NW'(3 * ((1 << N) - 1));
    // Intensity divisor 6*M and its rounded-up reciprocal. With this shift
    // the product gives the exact floor for every dividend the block sees.
    localparam int INT_K = 2 * N + 14;
    localparam int RW = N + 12;
    localparam longint INT_DIV = 6 * ((longint'(1) << N) - 1);
    localparam logic [RW-1:0] INT_RECIP =
        RW'(((longint'(1) << INT_K) + INT_DIV - 1) / INT_DIV);

    // The block never holds requests off.
    assign busy = 1'b0;

    // ---------------- Input stage ----------------
    logic [SW-1:0]        sum, spread;
    logic [N-1:0]         mn, absd;
    logic signed [N+2:0]  n2;
    logic signed [N:0]    d;
    logic signed [XW-1:0] x0, y0;
    logic [N+16:0]        yprod;
    logic signed [XW-1:0] n_x0, n_y0;
    logic signed [ZW-1:0] n_z0;
    t_hue_side            n_side0;

    always_comb begin
        sum = SW'(i_red) + SW'(i_green) + SW'(i_blue);
        mn = i_red;
        if (i_green < mn) begin
            mn = i_green;
        end
        if (i_blue < mn) begin
            mn = i_blue;
        end
        spread = SW'(sum - 3 * SW'(mn));
        n2 = (N+3)'(2 * $signed({3'b0, i_red}) - $signed({3'b0, i_green})
             - $signed({3'b0, i_blue}));
        d = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        absd = d[N] ? N'(-d) : N'(d);
        yprod = (N+17)'(absd) * (N+17)'(SQRT3_Q15);
        x0 = XW'(n2) <<< 15;
        y0 = $signed(XW'(yprod));
        // A vector in the left half plane is turned by -90 degrees first.
        if (x0 < 0) begin
            n_x0 = y0;
            n_y0 = -x0;
            n_z0 = Z_90;
        end else begin
            n_x0 = x0;
            n_y0 = y0;
            n_z0 = '0;
        end
        n_side0.gray = (n2 == 0) && (d == 0);
        n_side0.mirror = (i_blue > i_green);
    end

    logic                 r_vld0;
    logic signed [XW-1:0] r_x0, r_y0;
    logic signed [ZW-1:0] r_z0;
    t_hue_side            r_side0;
    logic [NW-1:0]        r_snum, r_inum;
    logic [DW-1:0]        r_sden;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= start && !busy;
        end
        r_x0 <= n_x0;
        r_y0 <= n_y0;
        r_z0 <= n_z0;
        r_side0 <= n_side0;
        // Saturation is (510*(sum-3*min) + sum) / (2*sum), intensity is
        // (510*sum + 3*M) / (6*M); both round to nearest this way.
        r_snum <= NW'(spread) * NW'(510) + NW'(sum);
        // A black pixel divides zero by one, so its saturation is zero.
        r_sden <= (sum == '0) ? DW'(1) : (DW'(sum) << 1);
        r_inum <= NW'(sum) * NW'(510) + M3;
    end

    // ---------------- Hue: row of CORDIC cells ----------------
    logic                 cv [0:CORDIC_STEPS];
    logic signed [XW-1:0] cx [0:CORDIC_STEPS];
    logic signed [XW-1:0] cy [0:CORDIC_STEPS];
    logic signed [ZW-1:0] cz [0:CORDIC_STEPS];
    t_hue_side            cs [0:CORDIC_STEPS];

    assign cv[0] = r_vld0;
    assign cx[0] = r_x0;
    assign cy[0] = r_y0;
    assign cz[0] = r_z0;
    assign cs[0] = r_side0;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        rth_cordic_cell #(
            .XW(XW),
            .STEP(k)
        ) u_cell (
            .i_clk(i_clk),
            .i_rst_n(i_rst_n),
            .i_vld(cv[k]),
            .i_x(cx[k]),
            .i_y(cy[k]),
            .i_z(cz[k]),
            .i_side(cs[k]),
            .o_vld(cv[k+1]),
            .o_x(cx[k+1]),
            .o_y(cy[k+1]),
            .o_z(cz[k+1]),
            .o_side(cs[k+1])
        );
    end

    // ---------------- Saturation: divider row ----------------
    logic [NW-1:0] srem [0:DIV_CELLS];
    logic [DW-1:0] sden [0:DIV_CELLS];
    logic [QW-1:0] sq   [0:DIV_CELLS];

    assign srem[0] = r_snum;
    assign sden[0] = r_sden;
    assign sq[0] = '0;

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
        rth_div_cell #(
            .NW(NW),
            .DW(DW),
            .QB(DIV_CELLS - 1 - k)
        ) u_sat (
            .i_clk(i_clk),
            .i_rem(srem[k]),
            .i_den(sden[k]),
            .i_q(sq[k]),
            .o_rem(srem[k+1]),
            .o_den(sden[k+1]),
            .o_q(sq[k+1])
        );
    end

    // ---------------- Intensity: reciprocal multiply ----------------
    logic [NW+RW-1:0] iprod;
    logic [QW-1:0]    n_iq;

    always_comb begin
        iprod = (NW+RW)'(r_inum) * (NW+RW)'(INT_RECIP);
        n_iq = iprod[INT_K +: QW];
    end

    // Delay the quotients so they meet the hue at the output register.
    logic [QW-1:0] r_sat_d [0:ALIGN-1];
    logic [QW-1:0] r_int_d [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        r_sat_d[0] <= sq[DIV_CELLS];
        for (int j = 1; j < ALIGN; j++) begin
            r_sat_d[j] <= r_sat_d[j-1];
        end
        r_int_d[0] <= n_iq;
        for (int j = 1; j <= CORDIC_STEPS; j++) begin
            r_int_d[j] <= r_int_d[j-1];
        end
    end

    // ---------------- Output stage for hue ----------------
    // The angle is clamped to 0..180 degrees, mirrored when blue is above
    // green, then scaled so a full turn is 180, rounded to nearest; gray gives 0.
    logic signed [ZW-1:0] zc, zm;
    logic [ZW-1:0]        zr;
    logic [7:0]           n_hue;

    always_comb begin
        zc = cz[CORDIC_STEPS];
        if (zc < 0) begin
            zc = '0;
        end
        if (zc > Z_180) begin
            zc = Z_180;
        end
        zm = cs[CORDIC_STEPS].mirror ? (Z_360 - zc) : zc;
        zr = (ZW'(zm) + ZW'(65536)) >> 17;
        if (cs[CORDIC_STEPS].gray) begin
            n_hue = '0;
        end else if (zr > ZW'(HUE_MAX)) begin
            n_hue = HUE_MAX;
        end else begin
            n_hue = zr[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= cv[CORDIC_STEPS];
        end
        o_hue <= n_hue;
    end

    assign o_saturation = r_sat_d[ALIGN-1];
    assign o_intensity = r_int_d[CORDIC_STEPS];

    // ---------------- Assertions ----------------
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue <= HUE_MAX))
        else $error("hue above its range");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, CORDIC_STEPS + 2))
        else $error("result without a matching request");

    a_gray_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_red == i_green && i_green == i_blue, CORDIC_STEPS + 2))
        |-> (o_hue == 8'd0 && o_saturation == 8'd0))
        else $error("gray pixel gave nonzero hue or saturation");

endmodule

`default_nettype wire

[rtl/core/rth_cordic_cell.sv]
// One CORDIC vectoring step of the hue chain.
// Depends on rth_pkg for the angle table and the sideband type.
`default_nettype none

module rth_cordic_cell #(
    parameter int XW = 28,
    parameter int STEP = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_vld,
    input  wire logic signed [XW-1:0]        i_x,
    input  wire logic signed [XW-1:0]        i_y,
    input  wire logic signed [rth_pkg::ZW-1:0] i_z,
    input  wire rth_pkg::t_hue_side          i_side,
    output logic                             o_vld,
    output logic signed [XW-1:0]             o_x,
    output logic signed [XW-1:0]             o_y,
    output logic signed [rth_pkg::ZW-1:0]    o_z,
    output rth_pkg::t_hue_side               o_side
);
    import rth_pkg::*;

    localparam logic signed [ZW-1:0] ANG = $signed({{(ZW-22){1'b0}}, ATAN_TAB[STEP]});

    logic signed [XW-1:0] n_x, n_y, xs, ys;
    logic signed [ZW-1:0] n_z;

    always_comb begin
        xs = i_x >>> STEP;
        ys = i_y >>> STEP;
        if (!i_y[XW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ANG;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_x <= n_x;
        o_y <= n_y;
        o_z <= n_z;
        o_side <= i_side;
    end

endmodule

`default_nettype wire

[rtl/core/rth_div_cell.sv]
// One restoring division step: decides one quotient bit per cycle.
// Depends on rth_pkg for the quotient width.
`default_nettype none

module rth_div_cell #(
    parameter int NW = 19,
    parameter int DW = 11,
    parameter int QB = 7
) (
    input  wire logic                    i_clk,
    input  wire logic [NW-1:0]           i_rem,
    input  wire logic [DW-1:0]           i_den,
    input  wire logic [rth_pkg::QW-1:0]  i_q,
    output logic [NW-1:0]                o_rem,
    output logic [DW-1:0]                o_den,
    output logic [rth_pkg::QW-1:0]       o_q
);
    import rth_pkg::*;

    logic [NW-1:0] shifted;
    logic          fits;

    always_comb begin
        shifted = NW'(i_den) << QB;
        fits = (i_rem >= shifted);
    end

    always_ff @(posedge i_clk) begin
        o_rem <= fits ? (i_rem - shifted) : i_rem;
        o_den <= i_den;
        o_q <= i_q | (fits ? (QW'(1) << QB) : '0);
    end

endmodule

`default_nettype wire

[tb/sv/hsi_checker.sv]
// Checker for the RGB to HSI pixel converter: watches requests and results,
// predicts hue, saturation and intensity in fixed point and compares them.
// Depends on nothing but the block's port widths.
`timescale 1ns / 1ps

module hsi_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_take,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic       res_valid,
    input  logic [7:0] hue,
    input  logic [7:0] saturation,
    input  logic [7:0] intensity,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] inten;
    } t_hsi;

    t_hsi pixel_queue[$];

    // Arctangent of 2^-i in degrees, scaled by 2^16.
    localparam longint ANGLE_STEP [0:15] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    function automatic longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    function automatic logic [7:0] hue_angle(longint r, longint g, longint b);
        longint n2, d, x, y, z, t, xs, ys, h;
        n2 = 2 * r - g - b;
        d = g - b;
        if (n2 == 0 && d == 0)
            return 8'd0;
        x = n2 * 32768;
        y = (d < 0 ? -d : d) * 56756;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = 90 * 65536;
        end
        for (int i = 0; i < 16; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += ANGLE_STEP[i];
            end else begin
                x -= ys;
                y += xs;
                z -= ANGLE_STEP[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 180 * 65536) z = 180 * 65536;
        if (b > g) z = 360 * 65536 - z;
        h = (z + 65536) >>> 17;
        if (h > 180) h = 180;
        return h[7:0];
    endfunction

    function automatic t_hsi pixel_to_hsi(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_hsi res;
        longint sum, mn, s, n;
        sum = r + g + b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        s = (sum == 0) ? 0 : (510 * (sum - 3 * mn) + sum) / (2 * sum);
        if (s > 255) s = 255;
        n = (510 * sum + 3 * 255) / (6 * 255);
        if (n > 255) n = 255;
        res.hue = hue_angle(r, g, b);
        res.sat = s[7:0];
        res.inten = n[7:0];
        return res;
    endfunction

    assign pending = pixel_queue.size();

    always @(posedge clk) begin
        t_hsi want;
        if (!rst_n) begin
            fail_count <= 0;
        end else begin
            if (res_valid) begin
                if (pixel_queue.size() == 0) begin
                    $display("%0t: result with no request pending: hue %0d sat %0d int %0d",
                             $time, hue, saturation, intensity);
                    fail_count <= fail_count + 1;
                end else begin
                    want = pixel_queue.pop_front();
                    if (want.hue !== hue || want.sat !== saturation
                        || want.inten !== intensity) begin
                        $display("%0t: expected hue %0d sat %0d int %0d, got %0d %0d %0d",
                                 $time, want.hue, want.sat, want.inten,
                                 hue, saturation, intensity);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req_take)
                pixel_queue.push_back(pixel_to_hsi(red, green, blue));
        end
    end

endmodule

[tb/sv/tb_top.sv]
// Top of the testbench for the RGB to HSI pixel converter.
// Drives pixel requests into rgb_to_hsi_pixel; hsi_checker does the checking.
`timescale 1ns / 1ps

module tb_top;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic [7:0] i_red = '0;
    logic [7:0] i_green = '0;
    logic [7:0] i_blue = '0;
    logic       busy;
    logic       o_valid;
    logic [7:0] o_hue;
    logic [7:0] o_saturation;
    logic [7:0] o_intensity;
    int         fail_count;
    int         pending;

    always #10 i_clk = ~i_clk;

    rgb_to_hsi_pixel #(.COMPONENT_BITS(8)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .o_valid(o_valid), .o_hue(o_hue), .o_saturation(o_saturation),
        .o_intensity(o_intensity)
    );

    hsi_checker u_checker (
        .clk(i_clk), .rst_n(i_rst_n), .req_take(start && !busy),
        .red(i_red), .green(i_green), .blue(i_blue),
        .res_valid(o_valid), .hue(o_hue), .saturation(o_saturation),
        .intensity(o_intensity), .fail_count(fail_count), .pending(pending)
    );

    // Sends one pixel request. start stays high from one request to the next
    // when there is no gap, so it is never lowered and raised in one step.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                          : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Random pixels, many of them biased toward gray, near-gray and
    // saturated colors where the hue angle and clamping get interesting.
    task automatic send_random_pixel();
        logic [7:0] r, g, b;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        case ($urandom_range(0, 5))
            0: begin
                g = r;
                b = r;
            end
            1: begin
                g = 8'(r + $urandom_range(0, 2) - 1);
                b = 8'(r + $urandom_range(0, 2) - 1);
            end
            2: begin
                // Blue just above green pushes hue toward a full turn.
                g = 8'($urandom_range(0, 250));
                b = 8'(g + $urandom_range(1, 3));
                r = 8'($urandom_range(200, 255));
            end
            3: begin
                r = ($urandom_range(0, 1)) ? 8'd255 : 8'd0;
                g = ($urandom_range(0, 1)) ? 8'd255 : g;
            end
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    initial begin
        int waited;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: black, white, grays, primaries, secondaries, dim and
        // near-gray pixels, and pixels whose hue lands near a full turn.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd100, 8'd101);
        send_pixel(8'd255, 8'd254, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd170, 8'd85, 8'd85);
        send_pixel(8'd85, 8'd170, 8'd170);
        send_pixel(8'd1, 8'd2, 8'd3);
        send_pixel(8'd254, 8'd253, 8'd252);

        // Hold off until every pending result has come back. Waiting on the
        // clock first lets the checker log the last request.
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < 800; n++) begin
            if ($urandom_range(0, 49) == 0)
                send_pixel(8'd255, 8'd255, 8'd255);
            else
                send_random_pixel();
            if (n % 200 == 199) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[rgb_to_hsi_pixel.f]
rtl/core/rth_pkg.sv
rtl/core/rth_cordic_cell.sv
rtl/core/rth_div_cell.sv
rtl/core/rgb_to_hsi_pixel.sv
tb/sv/hsi_checker.sv
tb/sv/tb_top.sv
